>>> hw/rtl/bdeq_pkg.sv
// Shared constants and codes for the bounded double-ended queue.
package bdeq_pkg;

  // Default number of ring entries
  localparam int unsigned DeqDepth = 4;

  // Fixed field widths
  localparam int unsigned ActionW = 3;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned KindW   = 2;
  localparam int unsigned FillW   = 3;

  // Action codes
  localparam logic [ActionW-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ActionW-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ActionW-1:0] ACT_ERA_FRONT = 3'd2;
  localparam logic [ActionW-1:0] ACT_ERA_BACK  = 3'd3;
  localparam logic [ActionW-1:0] ACT_DUMP      = 3'd4;

  // Result kinds
  localparam logic [KindW-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KindW-1:0] KIND_ELEMENT = 2'd1;
  localparam logic [KindW-1:0] KIND_EMPTY   = 2'd2;

  // Command codes between front and back
  localparam int unsigned CmdOpW = 2;
  localparam logic [CmdOpW-1:0] CMD_STATUS = 2'd0;
  localparam logic [CmdOpW-1:0] CMD_EMPTY  = 2'd1;
  localparam logic [CmdOpW-1:0] CMD_DUMP   = 2'd2;

  // Control from back to front
  typedef struct packed {
    logic dump_done;
  } bdeq_ctl_t;

endpackage

>>> hw/rtl/bounded_double_ended_queue_top.sv
// Top level of the bounded double-ended queue.
//
//   Channel   Handshake         Accepted when        Payload
//   -------   ---------------   ------------------   ----------------------------------
//   input     push / full       push && !full        action_i, value_i
//   result    empty / pop       pop && !empty        kind_o, element_o, applied_o,
//                                                    fill_o, last_o
//
// Inserts, erases and unknown actions each give one result word; up to two commands
// queue between front and back, so the front keeps going while a result waits. A dump
// of N entries reads the store one entry at a time in the back, each read word taken
// before the next read is issued, as set by the registered read port of the ring store,
// and the front stalls until the last read has been issued. Reset clears pointers,
// counts and queues at once; the store itself is never cleared and only live entries are read.
module bounded_double_ended_queue_top #(
  parameter int unsigned DEPTH = bdeq_pkg::DeqDepth
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [bdeq_pkg::ActionW-1:0]   action_i,
  input  logic signed [bdeq_pkg::ValueW-1:0] value_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [bdeq_pkg::KindW-1:0]     kind_o,
  output logic signed [bdeq_pkg::ValueW-1:0] element_o,
  output logic                           applied_o,
  output logic [bdeq_pkg::FillW-1:0]     fill_o,
  output logic                           last_o
);
  import bdeq_pkg::*;

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmdW = CmdOpW + 1 + CntW + IdxW;

  logic              cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic [CmdW-1:0]   cmd_wdata, cmd_rdata;
  bdeq_ctl_t         ctl;
  logic              ram_we, ram_re;
  logic [IdxW-1:0]   ram_waddr, ram_raddr;
  logic [ValueW-1:0] ram_wdata, ram_rdata;
  logic [ValueW-1:0] elem;

  // Accept and classify actions
  bdeq_front #(
    .Depth (DEPTH),
    .IdxW  (IdxW),
    .CntW  (CntW),
    .CmdW  (CmdW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .action_i    (action_i),
    .value_i     (value_i),
    .ctl_i       (ctl),
    .cmd_push_o  (cmd_push),
    .cmd_data_o  (cmd_wdata),
    .cmd_full_i  (cmd_full),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata)
  );

  // Decouple front and back
  bdeq_cmd_fifo #(
    .Width (CmdW)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_wdata),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_rdata),
    .empty_o (cmd_empty)
  );

  // Ring store
  bdeq_ram #(
    .Width (ValueW),
    .Depth (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Produce result words
  bdeq_back #(
    .Depth (DEPTH),
    .IdxW  (IdxW),
    .CntW  (CntW),
    .CmdW  (CmdW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_data_i  (cmd_rdata),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .ctl_o       (ctl),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata),
    .empty       (empty),
    .pop         (pop),
    .kind_o      (kind_o),
    .element_o   (elem),
    .applied_o   (applied_o),
    .fill_o      (fill_o),
    .last_o      (last_o)
  );

  assign element_o = signed'(elem);

endmodule

>>> hw/rtl/bdeq_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bdeq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bdeq_cmd_fifo.sv
// Two-entry command queue between the front and the back.
module bdeq_cmd_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store incoming command
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

>>> hw/rtl/bdeq_front.sv
// Front end: accepts actions, keeps ring pointers, writes the store, issues commands.
module bdeq_front #(
  parameter int unsigned Depth = bdeq_pkg::DeqDepth,
  parameter int unsigned IdxW  = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1),
  parameter int unsigned CmdW  = bdeq_pkg::CmdOpW + 1 + CntW + IdxW
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [bdeq_pkg::ActionW-1:0]    action_i,
  input  logic [bdeq_pkg::ValueW-1:0]     value_i,
  input  bdeq_pkg::bdeq_ctl_t             ctl_i,
  output logic                            cmd_push_o,
  output logic [CmdW-1:0]                 cmd_data_o,
  input  logic                            cmd_full_i,
  output logic                            ram_we_o,
  output logic [IdxW-1:0]                 ram_waddr_o,
  output logic [bdeq_pkg::ValueW-1:0]     ram_wdata_o
);
  import bdeq_pkg::*;

  logic [IdxW-1:0]   head_q, head_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              busy_q, busy_d;
  logic              accept;
  logic              not_full, not_empty;
  logic [IdxW-1:0]   head_dec, head_inc;
  logic [CntW:0]     tail_sum;
  logic [IdxW-1:0]   tail_idx;
  logic              applied;
  logic [CmdOpW-1:0] op;

  // Stall while the command queue is full or a dump still reads the store
  assign full     = cmd_full_i || busy_q;
  assign accept   = push && !full;

  assign not_full  = (count_q != CntW'(Depth));
  assign not_empty = (count_q != '0);

  // Ring arithmetic with wrap at the depth
  assign head_dec = (head_q == '0) ? IdxW'(Depth - 1) : head_q - IdxW'(1);
  assign head_inc = (head_q == IdxW'(Depth - 1)) ? '0 : head_q + IdxW'(1);
  assign tail_sum = (CntW+1)'(head_q) + (CntW+1)'(count_q);
  assign tail_idx = (tail_sum >= (CntW+1)'(Depth)) ? IdxW'(tail_sum - (CntW+1)'(Depth))
                                                   : IdxW'(tail_sum);

  // Classify the action and update pointers
  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    applied     = 1'b0;
    op          = CMD_STATUS;
    ram_we_o    = 1'b0;
    ram_waddr_o = head_dec;
    case (action_i)
      ACT_INS_FRONT: begin
        if (not_full) begin
          applied     = 1'b1;
          ram_we_o    = accept;
          ram_waddr_o = head_dec;
          head_d      = head_dec;
          count_d     = count_q + CntW'(1);
        end
      end
      ACT_INS_BACK: begin
        if (not_full) begin
          applied     = 1'b1;
          ram_we_o    = accept;
          ram_waddr_o = tail_idx;
          count_d     = count_q + CntW'(1);
        end
      end
      ACT_ERA_FRONT: begin
        if (not_empty) begin
          applied = 1'b1;
          head_d  = head_inc;
          count_d = count_q - CntW'(1);
        end
      end
      ACT_ERA_BACK: begin
        if (not_empty) begin
          applied = 1'b1;
          count_d = count_q - CntW'(1);
        end
      end
      ACT_DUMP: begin
        op = not_empty ? CMD_DUMP : CMD_EMPTY;
      end
      default: begin
        op = CMD_STATUS;
      end
    endcase
  end

  assign ram_wdata_o = value_i;
  assign cmd_push_o  = accept;
  assign cmd_data_o  = {op, applied, count_d, head_q};

  // Hold off new actions after a nonempty dump until the back has issued its last store read
  always_comb begin
    busy_d = busy_q;
    if (ctl_i.dump_done) begin
      busy_d = 1'b0;
    end
    if (accept && (op == CMD_DUMP)) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      busy_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      if (accept) begin
        head_q  <= head_d;
        count_q <= count_d;
      end
    end
  end

endmodule

>>> hw/rtl/bdeq_back.sv
// Back end: turns commands into result words and walks the store on a dump.
module bdeq_back #(
  parameter int unsigned Depth = bdeq_pkg::DeqDepth,
  parameter int unsigned IdxW  = $clog2(Depth),
  parameter int unsigned CntW  = $clog2(Depth + 1),
  parameter int unsigned CmdW  = bdeq_pkg::CmdOpW + 1 + CntW + IdxW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [CmdW-1:0]              cmd_data_i,
  input  logic                         cmd_empty_i,
  output logic                         cmd_pop_o,
  output bdeq_pkg::bdeq_ctl_t          ctl_o,
  output logic                         ram_re_o,
  output logic [IdxW-1:0]              ram_raddr_o,
  input  logic [bdeq_pkg::ValueW-1:0]  ram_rdata_i,
  output logic                         empty,
  input  logic                         pop,
  output logic [bdeq_pkg::KindW-1:0]   kind_o,
  output logic [bdeq_pkg::ValueW-1:0]  element_o,
  output logic                         applied_o,
  output logic [bdeq_pkg::FillW-1:0]   fill_o,
  output logic                         last_o
);
  import bdeq_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StDump = 1'b1;

  logic [CmdOpW-1:0] cmd_op;
  logic              cmd_applied;
  logic [CntW-1:0]   cmd_count;
  logic [IdxW-1:0]   cmd_start;

  logic              state_q, state_d;
  logic [IdxW-1:0]   rd_idx_q, rd_idx_d;
  logic [CntW-1:0]   remain_q, remain_d;
  logic [CntW-1:0]   dcount_q, dcount_d;
  logic              rd_pend_q, rd_pend_d;

  logic              out_valid_q, out_valid_d;
  logic [KindW-1:0]  kind_q, kind_d;
  logic [ValueW-1:0] elem_q, elem_d;
  logic              appl_q, appl_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic              last_q, last_d;
  logic              load;
  logic              slot_free;

  assign {cmd_op, cmd_applied, cmd_count, cmd_start} = cmd_data_i;

  // Output slot frees when empty or when its word leaves this cycle
  assign slot_free = !out_valid_q || pop;

  // Sequence commands and dump reads
  always_comb begin
    state_d         = state_q;
    rd_idx_d        = rd_idx_q;
    remain_d        = remain_q;
    dcount_d        = dcount_q;
    rd_pend_d       = 1'b0;
    cmd_pop_o       = 1'b0;
    ctl_o.dump_done = 1'b0;
    ram_re_o        = 1'b0;
    ram_raddr_o     = rd_idx_q;
    load            = 1'b0;
    kind_d          = kind_q;
    elem_d          = elem_q;
    appl_d          = appl_q;
    fill_d          = fill_q;
    last_d          = last_q;
    case (state_q)
      StIdle: begin
        if (!cmd_empty_i && slot_free) begin
          cmd_pop_o = 1'b1;
          case (cmd_op)
            CMD_DUMP: begin
              state_d  = StDump;
              rd_idx_d = cmd_start;
              remain_d = cmd_count;
              dcount_d = cmd_count;
            end
            CMD_EMPTY: begin
              load   = 1'b1;
              kind_d = KIND_EMPTY;
              elem_d = '0;
              appl_d = 1'b0;
              fill_d = '0;
              last_d = 1'b1;
            end
            default: begin
              load   = 1'b1;
              kind_d = KIND_STATUS;
              elem_d = '0;
              appl_d = cmd_applied;
              fill_d = FillW'(cmd_count);
              last_d = 1'b1;
            end
          endcase
        end
      end
      StDump: begin
        // Take the word read last cycle
        if (rd_pend_q) begin
          load   = 1'b1;
          kind_d = KIND_ELEMENT;
          elem_d = ram_rdata_i;
          appl_d = 1'b0;
          fill_d = FillW'(dcount_q);
          last_d = (remain_q == '0);
          if (remain_q == '0) begin
            state_d = StIdle;
          end
        end else if (slot_free && (remain_q != '0)) begin
          // Issue the next read and advance around the ring
          ram_re_o  = 1'b1;
          rd_pend_d = 1'b1;
          remain_d  = remain_q - CntW'(1);
          rd_idx_d  = (rd_idx_q == IdxW'(Depth - 1)) ? '0 : rd_idx_q + IdxW'(1);
          if (remain_q == CntW'(1)) begin
            ctl_o.dump_done = 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output slot valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b0;
    end
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      rd_pend_q   <= 1'b0;
      remain_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_pend_q   <= rd_pend_d;
      remain_q    <= remain_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    dcount_q <= dcount_d;
    if (load) begin
      kind_q <= kind_d;
      elem_q <= elem_d;
      appl_q <= appl_d;
      fill_q <= fill_d;
      last_q <= last_d;
    end
  end

  assign empty     = !out_valid_q;
  assign kind_o    = kind_q;
  assign element_o = elem_q;
  assign applied_o = appl_q;
  assign fill_o    = fill_q;
  assign last_o    = last_q;

endmodule
